FILE: src/enms_pkg.sv
// Shared types, constants and the angle quantiser for edge non-maximum suppression.
`timescale 1ns / 1ps
`default_nettype none

package enms_pkg;

	localparam int CFG_W       = 11;
	localparam int MAG_W       = 8;
	localparam int ANG_W       = 12;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 8;
	localparam int WIDTH_RESET = 640;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;

	localparam logic [1:0] ROWS_FULL = 2'd3;

	// Sector bounds in tenths of a degree
	localparam logic signed [ANG_W:0] BND_22  = 13'sd225;
	localparam logic signed [ANG_W:0] BND_67  = 13'sd675;
	localparam logic signed [ANG_W:0] BND_117 = 13'sd1175;
	localparam logic signed [ANG_W:0] BND_157 = 13'sd1575;

	typedef enum logic [2:0] {
		DIR_NONE = 3'd0,
		DIR_0    = 3'd1,
		DIR_45   = 3'd2,
		DIR_90   = 3'd3,
		DIR_135  = 3'd4
	} dir_t;

	// One line buffer word: direction and magnitude of the middle row, magnitude of the upper row
	typedef struct packed {
		dir_t             dir;
		logic [MAG_W-1:0] mid;
		logic [MAG_W-1:0] up;
	} line_t;

	typedef struct packed {
		logic             last_of_frame;
		logic [MAG_W-1:0] edge_value;
	} res_t;

	// Map a gradient angle onto one of four directions; an angle on a bound gets none
	function automatic dir_t quantize(input logic [ANG_W-1:0] ang);
		logic signed [ANG_W:0] a;
		logic signed [ANG_W:0] aa;
		dir_t d;
		a  = {ang[ANG_W-1], ang};
		aa = a[ANG_W] ? -a : a;
		if (aa < BND_22 || aa > BND_157) begin
			d = DIR_0;
		end else if ((a > BND_22 && a < BND_67) || (a < -BND_117 && a > -BND_157)) begin
			d = DIR_45;
		end else if (aa > BND_67 && aa < BND_117) begin
			d = DIR_90;
		end else if ((a > BND_117 && a < BND_157) || (a < -BND_22 && a > -BND_67)) begin
			d = DIR_135;
		end else begin
			d = DIR_NONE;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: src/edge_nonmax_suppression.sv
// Top level: streaming Canny non-maximum suppression with a line buffer that holds two rows.
//
// Input stream s_*: one request per pixel (s_tuser = 0) or per flush (s_tuser = 1).
// A pixel's result leaves once image_width+1 further items have entered the window,
// so a frame ends with flush requests, one per pending result; the one that empties
// the frame carries m_tlast. Output stream m_*: one edge value per result.
// Configuration cfg_*: write the row width while the block is idle; it restarts the frame.
// Throughput: one request per cycle while s_tready is high. A pixel or flush step reads
// the line buffer at issue, then in the step stage updates the window and judges the
// centre; its result is registered into the output queue and then shows on m_tvalid.
// The first flush of a frame shorter than image_width+1 items runs padding steps, one a
// cycle over the line buffer port while the output queue has room, and holds s_tready
// low until the padding step that produces its result.
// Results queue in a four-entry output buffer; when the receiver stalls, s_tready drops
// as soon as in-flight results could fill it, so nothing is lost.
// Reset clears all counters and the window control and sets the width to 640; the line
// buffers are not cleared, since entries from before the frame never reach a result.
`timescale 1ns / 1ps
`default_nettype none

module edge_nonmax_suppression #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Pixel and flush requests
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [enms_pkg::IN_TDATA_W-1:0]    s_tdata,  // magnitude[7:0], angle_tenths[19:8]
	input  wire logic                               s_tuser,  // cmd
	// Results
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [enms_pkg::OUT_TDATA_W-1:0]        m_tdata,  // edge_value[7:0]
	output logic                                    m_tlast,  // last_of_frame
	// Row width register
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [enms_pkg::CFG_W-1:0]         cfg_data
);

	import enms_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CNT_W = $clog2(MAX_WIDTH + 2);
	localparam int PH_W  = $clog2(2 * MAX_WIDTH + 3);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	// Width register, held in clamped form
	logic [CNT_W-1:0] w_eff_q;
	logic [CNT_W-1:0] wp1_q;
	logic             w_ge2_q;

	// Frame control
	logic [COL_W-1:0] col_q;
	logic [1:0]       rows_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] pend_q;
	logic [PH_W-1:0]  ph_q;
	logic             busy_q;

	// Output queue
	res_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   occ_q;

	// Step stage
	logic             s1_valid_s1;
	logic [MAG_W-1:0] mag_s1;
	dir_t             dir_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	logic             last_s1;
	logic             has_up_s1;
	logic             lft_s1;
	logic             rgt_s1;
	logic             fgt0_s1;
	logic             fgt1_s1;
	logic             fgt2_s1;
	logic             fgtw_s1;

	// Line buffer and window
	line_t            line_mem [MAX_WIDTH];
	line_t            rd_q;
	line_t            fwd_word_q;
	logic             fwd_q;
	line_t            rd_eff;
	line_t            wr_word;
	logic [MAG_W-1:0] wm1_q [3];
	logic [MAG_W-1:0] wm2_q [3];
	dir_t             wd_q;

	// Issue-side signals
	logic             cfg_fire;
	logic             s_fire;
	logic             can_issue;
	logic             is_pix;
	logic             flush_go;
	logic             is_ph;
	logic             step;
	logic             restart_pix;
	logic [COL_W-1:0] col_b;
	logic [1:0]       rows_b;
	logic [CNT_W-1:0] fill_b;
	logic [CNT_W-1:0] pend_b;
	logic             emit;
	logic             c0;
	logic             has_up;
	logic             lft;
	logic [CNT_W-1:0] col_inc;
	logic [COL_W-1:0] col_nx;
	logic             fgt1;
	logic             fgt2;
	logic             fgtw;
	logic             last;
	logic [CNT_W-1:0] pend_nx;
	logic [MAG_W-1:0] step_mag;
	dir_t             step_dir;

	// Config decode
	logic [CMP_W-1:0] cfg_ext;
	logic [CMP_W-1:0] cfg_sel;
	logic [CNT_W-1:0] w_new;

	// Judge
	logic [MAG_W-1:0] nb [3][3];
	logic             ok [3][3];
	logic [MAG_W-1:0] ctr;
	logic             kill;
	res_t             res;
	logic             push;
	logic             pop;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Clamp the width: zero acts as one, anything above the buffer depth as the depth
	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext == '0) begin
			cfg_sel = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
			cfg_sel = CMP_W'(MAX_WIDTH);
		end else begin
			cfg_sel = cfg_ext;
		end
		w_new = CNT_W'(cfg_sel);
	end

	// Issue only when the output queue can take every result that may still arrive
	assign push      = s1_valid_s1 && emit_s1;
	assign pop       = m_tvalid && m_tready;
	assign can_issue = (occ_q + (FIFO_AW+1)'(push)) < (FIFO_AW+1)'(FIFO_DEPTH);
	assign s_tready  = can_issue && !busy_q;
	assign s_fire    = s_tvalid && s_tready;

	assign is_pix   = s_fire && !s_tuser;
	assign flush_go = s_fire && s_tuser && (pend_q != '0);
	assign is_ph    = flush_go || (busy_q && can_issue);
	assign step     = is_pix || is_ph;

	// A pixel after padding steps starts a fresh frame
	assign restart_pix = is_pix && (ph_q != '0);
	assign col_b  = restart_pix ? '0 : col_q;
	assign rows_b = restart_pix ? '0 : rows_q;
	assign fill_b = restart_pix ? '0 : fill_q;
	assign pend_b = restart_pix ? '0 : pend_q;

	assign emit    = fill_b >= wp1_q;
	assign c0      = (col_b == '0);
	assign has_up  = (rows_b == ROWS_FULL);
	assign lft     = c0 ? w_ge2_q : (CNT_W'(col_b) >= CNT_W'(2));
	assign col_inc = CNT_W'(col_b) + CNT_W'(1);
	assign col_nx  = (col_inc >= w_eff_q) ? '0 : col_inc[COL_W-1:0];

	// Padding positions inside the window count as outside the image
	assign fgt1 = is_ph && (ph_q != '0);
	assign fgt2 = is_ph && (ph_q >= PH_W'(2));
	assign fgtw = is_ph && (ph_q >= PH_W'(w_eff_q));
	assign last = is_ph && emit && (pend_q == CNT_W'(1));

	always_comb begin
		if (is_pix) begin
			pend_nx = emit ? pend_b : pend_b + CNT_W'(1);
		end else begin
			pend_nx = emit ? pend_q - CNT_W'(1) : pend_q;
		end
	end

	assign step_mag = is_ph ? '0 : s_tdata[MAG_W-1:0];
	assign step_dir = is_ph ? DIR_NONE : quantize(s_tdata[MAG_W+ANG_W-1:MAG_W]);

	// Width register and frame control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= CNT_W'(RST_W);
			wp1_q   <= CNT_W'(RST_W + 1);
			w_ge2_q <= (RST_W >= 2);
			col_q   <= '0;
			rows_q  <= '0;
			fill_q  <= '0;
			pend_q  <= '0;
			ph_q    <= '0;
			busy_q  <= 1'b0;
		end else if (cfg_fire) begin
			w_eff_q <= w_new;
			wp1_q   <= w_new + CNT_W'(1);
			w_ge2_q <= (w_new >= CNT_W'(2));
			col_q   <= '0;
			rows_q  <= '0;
			fill_q  <= '0;
			pend_q  <= '0;
			ph_q    <= '0;
			busy_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				// Frame drained: next pixel begins at row 0, column 0
				col_q  <= '0;
				rows_q <= '0;
				fill_q <= '0;
				pend_q <= '0;
				ph_q   <= '0;
				busy_q <= 1'b0;
			end else begin
				col_q  <= col_nx;
				rows_q <= (c0 && !has_up) ? rows_b + 2'd1 : rows_b;
				fill_q <= emit ? fill_b : fill_b + CNT_W'(1);
				pend_q <= pend_nx;
				ph_q   <= is_ph ? ph_q + PH_W'(1) : '0;
				busy_q <= is_ph && !emit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mag_s1    <= step_mag;
			dir_s1    <= step_dir;
			col_s1    <= col_b;
			emit_s1   <= emit;
			last_s1   <= last;
			has_up_s1 <= has_up;
			lft_s1    <= lft;
			rgt_s1    <= !c0;
			fgt0_s1   <= is_ph;
			fgt1_s1   <= fgt1;
			fgt2_s1   <= fgt2;
			fgtw_s1   <= fgtw;
		end
	end

	// Line buffer: read at issue, write back in the step stage; bypass a same-column write
	assign rd_eff  = fwd_q ? fwd_word_q : rd_q;
	assign wr_word = '{dir: dir_s1, mid: mag_s1, up: rd_eff.mid};

	always_ff @(posedge clk) begin
		if (step) begin
			rd_q       <= line_mem[col_b];
			fwd_q      <= s1_valid_s1 && (col_s1 == col_b);
			fwd_word_q <= wr_word;
		end
		if (s1_valid_s1) begin
			line_mem[col_s1] <= wr_word;
		end
	end

	// Window: advance one column per step
	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				wm1_q[r] <= wm2_q[r];
			end
			wm2_q[0] <= rd_eff.up;
			wm2_q[1] <= rd_eff.mid;
			wm2_q[2] <= mag_s1;
			wd_q     <= rd_eff.dir;
		end
	end

	// Judge the centre against the two neighbours along its direction
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nb[r][0] = wm1_q[r];
			nb[r][1] = wm2_q[r];
			ok[r][0] = lft_s1 && ((r != 0) || has_up_s1);
			ok[r][1] = (r != 0) || has_up_s1;
			ok[r][2] = rgt_s1 && ((r != 0) || has_up_s1);
		end
		nb[0][2] = rd_eff.up;
		nb[1][2] = rd_eff.mid;
		nb[2][2] = mag_s1;
		ok[2][0] = ok[2][0] && !fgt2_s1;
		ok[2][1] = ok[2][1] && !fgt1_s1;
		ok[2][2] = ok[2][2] && !fgt0_s1;
		ok[1][2] = ok[1][2] && !fgtw_s1;
		ctr = wm2_q[1];
		unique case (wd_q)
			DIR_0:   kill = (ok[1][0] && ctr < nb[1][0]) || (ok[1][2] && ctr < nb[1][2]);
			DIR_45:  kill = (ok[2][0] && ctr < nb[2][0]) || (ok[0][2] && ctr < nb[0][2]);
			DIR_90:  kill = (ok[0][1] && ctr < nb[0][1]) || (ok[2][1] && ctr < nb[2][1]);
			DIR_135: kill = (ok[0][0] && ctr < nb[0][0]) || (ok[2][2] && ctr < nb[2][2]);
			default: kill = 1'b0;
		endcase
		res.edge_value    = kill ? '0 : ctr;
		res.last_of_frame = last_s1;
	end

	// Output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			occ_q <= occ_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign m_tvalid = (occ_q != '0);
	assign m_tdata  = fifo_q[rd_ptr_q].edge_value;
	assign m_tlast  = fifo_q[rd_ptr_q].last_of_frame;

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (occ_q != (FIFO_AW+1)'(FIFO_DEPTH)))
		else $error("result pushed into a full output queue");

	a_drain_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready)
		else $error("request taken during padding steps");

	a_last_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && last_s1) |-> (pend_q == '0 && !busy_q))
		else $error("frame end result left results pending");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= wp1_q)
		else $error("fill count beyond window depth");

endmodule

`default_nettype wire

FILE: dv/edge_nonmax_suppression_checker.sv
// Request kinds and the checker that predicts and compares edge non-maximum suppression results.
`timescale 1ns / 1ps

package enms_tb_pkg;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

endpackage

module edge_nonmax_suppression_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [enms_pkg::IN_TDATA_W-1:0]  s_tdata,  // magnitude[7:0], angle_tenths[19:8]
	input  logic                             s_tuser,  // cmd
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [enms_pkg::OUT_TDATA_W-1:0] m_tdata,  // edge_value[7:0]
	input  logic                             m_tlast,  // last_of_frame
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [enms_pkg::CFG_W-1:0]       cfg_data,
	output int                               mismatches,
	output int                               outstanding,
	output int                               results_seen
);

	import enms_pkg::*;
	import enms_tb_pkg::*;

	// Sector bounds in tenths of a degree
	localparam int B22  = 225;
	localparam int B67  = 675;
	localparam int B117 = 1175;
	localparam int B157 = 1575;

	typedef struct {
		logic [MAG_W-1:0] value;
		logic             last_flag;
	} edge_word_t;

	edge_word_t expected_edges[$];

	logic [CFG_W-1:0] row_width;
	logic [MAG_W-1:0] upper_row [MAX_WIDTH];
	logic [MAG_W-1:0] middle_row [MAX_WIDTH];
	dir_t             dir_row [MAX_WIDTH];
	logic [MAG_W-1:0] win_mag [3][3];
	dir_t             win_dir [3];
	int               col;
	int               rows_seen;
	int               pending;
	int               fill;
	int               phantom;

	function automatic int width_eff();
		int w;
		w = row_width;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic dir_t angle_sector(input logic [ANG_W-1:0] raw);
		int a;
		int mag_a;
		dir_t d;
		a = $signed(raw);
		mag_a = (a < 0) ? -a : a;
		if (mag_a < B22 || mag_a > B157) begin
			d = DIR_0;
		end else if ((a > B22 && a < B67) || (a < -B117 && a > -B157)) begin
			d = DIR_45;
		end else if (mag_a > B67 && mag_a < B117) begin
			d = DIR_90;
		end else if ((a > B117 && a < B157) || (a < -B22 && a > -B67)) begin
			d = DIR_135;
		end else begin
			d = DIR_NONE;
		end
		return d;
	endfunction

	// Window cells are indexed row*3+column; row 0 is the upper row
	function automatic logic [MAG_W-1:0] judge_centre(input logic [8:0][MAG_W-1:0] nb,
			input logic [8:0] ok, input dir_t d);
		int a;
		int b;
		logic [MAG_W-1:0] ctr;
		ctr = nb[4];
		case (d)
			DIR_0: begin
				a = 3; b = 5;
			end
			DIR_45: begin
				a = 6; b = 2;
			end
			DIR_90: begin
				a = 1; b = 7;
			end
			DIR_135: begin
				a = 0; b = 8;
			end
			default: begin
				return ctr;
			end
		endcase
		if (ok[a] && ctr < nb[a]) return '0;
		if (ok[b] && ctr < nb[b]) return '0;
		return ctr;
	endfunction

	task automatic frame_restart();
		col = 0;
		rows_seen = 0;
		pending = 0;
		fill = 0;
		phantom = 0;
	endtask

	// Advance the window by one column and judge the delayed centre when asked
	task automatic window_step(input logic [MAG_W-1:0] mag, input dir_t d, input bit emit,
			output logic [MAG_W-1:0] res);
		int w;
		int c;
		int f;
		int r;
		int k;
		bit has_up;
		logic [8:0][MAG_W-1:0] nb;
		logic [8:0] ok;
		logic [MAG_W-1:0] um;
		logic [MAG_W-1:0] mm;
		dir_t md;
		res = '0;
		nb = '0;
		ok = '0;
		w = width_eff();
		c = (col < w) ? col : 0;
		f = phantom;
		has_up = (rows_seen == 3);
		if (c == 0) begin
			if (emit) begin
				for (r = 0; r < 3; r++) begin
					nb[r*3]     = win_mag[r][1];
					nb[r*3 + 1] = win_mag[r][2];
					ok[r*3]     = (w >= 2) && (r != 0 || has_up);
					ok[r*3 + 1] = (r != 0 || has_up);
				end
				if (f > 2) ok[6] = 1'b0;
				if (f > 1) ok[7] = 1'b0;
				res = judge_centre(nb, ok, win_dir[2]);
			end
			if (rows_seen < 3) rows_seen++;
		end
		um = upper_row[c];
		mm = middle_row[c];
		md = dir_row[c];
		upper_row[c] = mm;
		middle_row[c] = mag;
		dir_row[c] = d;
		for (r = 0; r < 3; r++) begin
			win_mag[r][0] = win_mag[r][1];
			win_mag[r][1] = win_mag[r][2];
		end
		win_mag[0][2] = um;
		win_mag[1][2] = mm;
		win_mag[2][2] = mag;
		win_dir[0] = win_dir[1];
		win_dir[1] = win_dir[2];
		win_dir[2] = md;
		if (c != 0 && emit) begin
			for (r = 0; r < 3; r++) begin
				for (k = 0; k < 3; k++) begin
					nb[r*3 + k] = win_mag[r][k];
					ok[r*3 + k] = (k != 0 || c >= 2) && (r != 0 || has_up);
				end
			end
			if (f > 2) ok[6] = 1'b0;
			if (f > 1) ok[7] = 1'b0;
			if (f > 0) ok[8] = 1'b0;
			if (w < f) ok[5] = 1'b0;
			res = judge_centre(nb, ok, win_dir[1]);
		end
		col = (c + 1 >= w) ? 0 : c + 1;
	endtask

	task automatic predict_pixel(input logic [MAG_W-1:0] mag, input logic [ANG_W-1:0] ang);
		int w;
		bit emit;
		logic [MAG_W-1:0] res;
		edge_word_t e;
		w = width_eff();
		if (phantom > 0) frame_restart();
		emit = (fill >= w + 1);
		if (!emit) begin
			fill++;
			pending++;
		end
		window_step(mag, angle_sector(ang), emit, res);
		if (emit) begin
			e.value = res;
			e.last_flag = 1'b0;
			expected_edges.insert(expected_edges.size(), e);
		end
	endtask

	// Pad with absent pixels until one pending centre can be judged
	task automatic predict_flush();
		int w;
		int steps;
		bit emit;
		bit done;
		logic [MAG_W-1:0] res;
		edge_word_t e;
		if (pending == 0) return;
		w = width_eff();
		steps = 0;
		done = 1'b0;
		res = '0;
		while (!done && steps <= MAX_WIDTH + 1) begin
			phantom++;
			emit = (fill >= w + 1);
			if (!emit) fill++;
			window_step('0, DIR_NONE, emit, res);
			done = emit;
			steps++;
		end
		pending--;
		e.value = res;
		e.last_flag = (pending == 0);
		expected_edges.insert(expected_edges.size(), e);
		if (pending == 0) frame_restart();
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_word_t e;
		if (!arst_n) begin
			row_width = CFG_W'(WIDTH_RESET);
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
				dir_row[i] = DIR_NONE;
			end
			for (int i = 0; i < 3; i++) begin
				win_dir[i] = DIR_NONE;
				for (int j = 0; j < 3; j++) win_mag[i][j] = '0;
			end
			frame_restart();
			expected_edges.delete();
			mismatches = 0;
			outstanding = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				row_width = cfg_data;
				frame_restart();
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_FLUSH) begin
					predict_flush();
				end else begin
					predict_pixel(s_tdata[MAG_W-1:0], s_tdata[MAG_W +: ANG_W]);
				end
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_edges.size() == 0) begin
					report_mismatch($sformatf("unexpected result edge_value=%0d last=%0b",
						m_tdata, m_tlast));
				end else begin
					e = expected_edges.pop_front();
					if (m_tdata[MAG_W-1:0] !== e.value)
						report_mismatch($sformatf("edge_value %0d, expected %0d",
							m_tdata[MAG_W-1:0], e.value));
					if (m_tlast !== e.last_flag)
						report_mismatch($sformatf("last_of_frame %0b, expected %0b",
							m_tlast, e.last_flag));
				end
			end
			outstanding = expected_edges.size();
		end
	end

endmodule

FILE: dv/edge_nonmax_suppression_test.sv
// Stimulus and verdict for the edge non-maximum suppression block.
`timescale 1ns / 1ps

module edge_nonmax_suppression_test;

	import enms_pkg::*;
	import enms_tb_pkg::*;

	localparam int MAX_WIDTH   = 1024;
	localparam int ITEMS       = 1650;
	localparam int IDLE_PCT    = 23;
	localparam int CYCLE_LIMIT = 500000;
	// Quiet window, counted in requests: neither side idles inside it
	localparam int CALM_FROM   = 700;
	localparam int CALM_TO     = 1000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = CMD_PIXEL;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data  = '0;

	int mismatches;
	int outstanding;
	int results_seen;
	int cycles = 0;

	// Stimulus bookkeeping: how many results the current frame still owes
	bit calm = 1'b0;
	int requests = 0;
	int widths_written = 0;
	int weff = WIDTH_RESET;
	int frame_px = 0;
	int owed = 0;
	bit draining = 1'b0;

	edge_nonmax_suppression #(
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	edge_nonmax_suppression_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) nms_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.results_seen(results_seen)
	);

	always #2 clk = ~clk;

	// Receiver back-pressure: stall about one cycle in four, never inside the quiet window
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Watchdog: a run that hangs on a handshake ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("edge_nonmax_suppression test failed");
			$finish;
		end
	end

	// Offer one request, possibly after some idle cycles, and hold it until accepted.
	// s_tvalid is left high on return so back-to-back requests never toggle it.
	task automatic send_request(input logic cmd, input logic [MAG_W-1:0] mag,
			input logic [ANG_W-1:0] ang);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, ang, mag};
		do @(posedge clk); while (!s_tready);
		// Track what the frame owes, so flushes can be counted out
		if (cmd == CMD_PIXEL) begin
			if (draining) begin
				owed = 0;
				frame_px = 0;
				draining = 1'b0;
			end
			if (frame_px < weff + 1) owed++;
			frame_px++;
			requests++;
		end else if (owed > 0) begin
			owed--;
			requests++;
			if (owed == 0) begin
				frame_px = 0;
				draining = 1'b0;
			end else begin
				draining = 1'b1;
			end
		end
	endtask

	// Drop valid and hold until every predicted result has left the block
	task automatic drain_wait();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Write the row width with the block idle; the frame restarts
	task automatic write_width(input logic [CFG_W-1:0] w);
		drain_wait();
		// Pixels that owe nothing may still be in the pipeline
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		weff = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
		owed = 0;
		frame_px = 0;
		draining = 1'b0;
		widths_written++;
	endtask

	initial begin
		logic [CFG_W-1:0] edge_widths [6];
		logic [CFG_W-1:0] w;
		logic [MAG_W-1:0] mag;
		logic [ANG_W-1:0] ang;
		int angle_bounds [8];
		int frame;
		int npx;
		int n;
		int mode;
		bit skip_cfg;

		edge_widths  = '{11'd1, 11'd0, 11'd2, 11'd2047, 11'd3, 11'd1024};
		angle_bounds = '{225, -225, 675, -675, 1175, -1175, 1575, -1575};
		skip_cfg = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short frame at the reset width: the first flush pads the whole window.
		// Covers full scale, an angle past 180 degrees and an angle on a bound.
		send_request(CMD_PIXEL, 8'd255, 12'd0);
		send_request(CMD_PIXEL, 8'd0, 12'h800);
		send_request(CMD_PIXEL, 8'd128, 12'd225);
		repeat (3) send_request(CMD_FLUSH, 8'($urandom), 12'($urandom));
		// Flush with nothing pending: ignored
		send_request(CMD_FLUSH, 8'd0, 12'd0);

		// Four rows of three, every direction and several bounds, then a full drain
		write_width(11'd3);
		send_request(CMD_PIXEL, 8'd90,  12'd0);
		send_request(CMD_PIXEL, 8'd200, 12'd450);
		send_request(CMD_PIXEL, 8'd90,  12'd900);
		send_request(CMD_PIXEL, 8'd200, 12'd1350);
		send_request(CMD_PIXEL, 8'd255, 12'(-450));
		send_request(CMD_PIXEL, 8'd200, 12'(-1350));
		send_request(CMD_PIXEL, 8'd90,  12'(-900));
		send_request(CMD_PIXEL, 8'd255, 12'd1800);
		send_request(CMD_PIXEL, 8'd90,  12'd675);
		send_request(CMD_PIXEL, 8'd0,   12'd1175);
		send_request(CMD_PIXEL, 8'd255, 12'(-1575));
		send_request(CMD_PIXEL, 8'd0,   12'(-225));
		repeat (4) send_request(CMD_FLUSH, 8'($urandom), 12'($urandom));

		// Random frames: mostly narrow rows, a few at the width extremes
		frame = 0;
		while (requests < ITEMS) begin
			calm = (requests >= CALM_FROM && requests < CALM_TO);
			if (frame < 6) begin
				write_width(edge_widths[frame]);
			end else if (!skip_cfg && $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 19))
					0: w = 11'd1;
					1: w = 11'd2;
					2: w = 11'd0;
					3: w = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'($urandom_range(1025, 2047));
					default: w = 11'($urandom_range(3, 12));
				endcase
				write_width(w);
			end
			skip_cfg = 1'b0;

			// Wide rows get short frames so the padding stays cheap
			npx = (weff >= 64) ? $urandom_range(1, 6) : $urandom_range(1, weff * 6 + 4);
			repeat (npx) begin
				case ($urandom_range(0, 3))
					0: mag = 8'($urandom_range(0, 3));
					1: mag = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
					default: mag = 8'($urandom);
				endcase
				case ($urandom_range(0, 5))
					0: ang = 12'(angle_bounds[$urandom_range(0, 7)]);
					1: ang = 12'($urandom);
					default: ang = 12'($urandom_range(0, 3600) - 1800);
				endcase
				send_request(CMD_PIXEL, mag, ang);
			end

			// Once mid-frame, hold the sender until the block has caught up
			if (frame == 9) drain_wait();

			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				n = owed;
				repeat (n) send_request(CMD_FLUSH, 8'($urandom), 12'($urandom));
				if ($urandom_range(0, 2) == 0)
					send_request(CMD_FLUSH, 8'($urandom), 12'($urandom));
			end else if (mode < 8 && owed >= 2) begin
				// Part of the drain, then a pixel cuts it short
				n = $urandom_range(1, owed - 1);
				repeat (n) send_request(CMD_FLUSH, 8'($urandom), 12'($urandom));
				skip_cfg = 1'b1;
			end
			frame++;
		end
		calm = 1'b0;

		drain_wait();
		repeat (10) @(posedge clk);

		$display("covered %0d requests in %0d random frames after the directed part,",
			requests, frame);
		$display("%0d width writes and %0d results compared", widths_written, results_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("edge_nonmax_suppression test passed");
		end else begin
			$display("edge_nonmax_suppression test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/enms_pkg.sv
src/edge_nonmax_suppression.sv
dv/edge_nonmax_suppression_checker.sv
dv/edge_nonmax_suppression_test.sv
